### src/aps_pkg.sv
`default_nettype none
package aps_pkg;

    // Size of the process table; entry 0 is the idle process.
    localparam int NPROC  = 16;
    localparam int PROC_W = (NPROC > 1) ? $clog2(NPROC) : 1;

    // Stream payload widths.
    localparam int IN_TDATA_W  = 72;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 8;
    localparam int OUT_TUSER_W = 2;

    localparam logic [15:0] QUANTUM_RESET = 16'd50;
    localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

    typedef enum logic [1:0] {
        RUN_READY   = 2'd0,
        RUN_RUNNING = 2'd1,
        RUN_STOPPED = 2'd2,
        RUN_WAITING = 2'd3
    } t_run;

    typedef enum logic [2:0] {
        OP_YIELD   = 3'd0,
        OP_READY   = 3'd1,
        OP_RESUME  = 3'd2,
        OP_STOP    = 3'd3,
        OP_CREATE  = 3'd4,
        OP_ALARM   = 3'd5,
        OP_REMOVE  = 3'd6,
        OP_UNUSED  = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        KIND_ALARM  = 2'd0,
        KIND_CHILD  = 2'd1,
        KIND_SWITCH = 2'd2,
        KIND_DONE   = 2'd3
    } t_kind;

endpackage
`default_nettype wire

### src/aging_process_scheduler.sv
`default_nettype none
// Aging process scheduler over a table of NPROC entries, entry 0 being idle.
//
// Channels: the slave stream carries one command item (operation in tuser,
// target entry, parent, alarm time and current tick in tdata). The master
// stream returns result items: alarm signals, a child-stopped signal, a
// switch to the chosen entry, or done; tlast marks the final result of a
// command. A separate write channel loads the 16-bit quantum register; it is
// always ready and should only be written while the block is idle.
//
// Timing: one command at a time, taken only while the sequencer is idle. A
// table operation returns one done item. A yield or stop walks entries 1 to
// NPROC-1 twice, one per cycle for alarms (holding while an expired alarm
// waits for a free output register) and again for selection; a stop first
// returns its child-stopped result. The selection walk uses the one shared
// compare and saturating increment.
//
// Reset (synchronous, active low) leaves only idle valid and running, all
// counters, alarms and parents at zero, and the quantum at 50. When the
// receiver stalls, the finished result waits in the output register and the
// sequencer holds at its next result until that register frees up.
module aging_process_scheduler (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    // Command stream. tuser: operation[2:0].
    // tdata: proc[3:0], parent[7:4], alarm_time[39:8], now[71:40].
    input  wire                             i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  wire [aps_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    input  wire [aps_pkg::IN_TUSER_W-1:0]   i_s_axis_tuser,
    // Result stream. tuser: kind[1:0]. tdata: target[3:0], zeros[7:4].
    output logic                            o_m_axis_tvalid,
    input  wire                             i_m_axis_tready,
    output logic [aps_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic [aps_pkg::OUT_TUSER_W-1:0] o_m_axis_tuser,
    output logic                            o_m_axis_tlast,
    // Quantum register write channel.
    input  wire                             i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire [15:0]                      i_cfg_data
);
    import aps_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ALARM,
        S_SELECT,
        S_FINISH
    } t_state;

    t_state              r_state;
    logic [15:0]         r_quantum;

    // Process table.
    logic [NPROC-1:0]    r_valid;
    t_run                r_run     [NPROC];
    logic [15:0]         r_count   [NPROC];
    logic [31:0]         r_alarm   [NPROC];
    logic [PROC_W-1:0]   r_parent  [NPROC];
    logic [PROC_W-1:0]   r_cur;

    // Latched command.
    t_op                 r_op;
    logic [3:0]          r_proc;
    logic [3:0]          r_par;
    logic [31:0]         r_at;
    logic [31:0]         r_now;

    // Walk index and best candidate so far.
    logic [PROC_W-1:0]   r_idx;
    logic [PROC_W-1:0]   r_best;
    logic [15:0]         r_best_cnt;

    // Output register.
    logic                r_out_valid;
    t_kind               r_out_kind;
    logic [3:0]          r_out_target;
    logic                r_out_last;

    logic                out_free;
    logic                out_load;
    logic                proc_ok;
    logic                alarm_hit;
    logic                cand;
    logic                beats;
    logic [15:0]         cnt_rd;
    logic [15:0]         inc_src;
    logic [15:0]         inc_res;
    logic                idx_last;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'd0, r_out_target};
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tlast  = r_out_last;

    // A new result may be loaded when the output register is empty or drains now.
    assign out_free = !r_out_valid || i_m_axis_tready;

    // The sequencer puts a new result into the output register this cycle.
    assign out_load = out_free && ((r_state == S_EXEC && r_op != OP_YIELD) ||
                                   (r_state == S_ALARM && alarm_hit) ||
                                   (r_state == S_FINISH));

    // Target entry must be a real, non-idle entry of the table.
    assign proc_ok  = (r_proc != 4'd0) && (32'(r_proc) < NPROC);
    assign idx_last = (r_idx == PROC_W'(NPROC - 1));

    // These table reads all go through the one walk index.
    assign cnt_rd    = r_count[r_idx];
    assign alarm_hit = r_valid[r_idx] && (r_alarm[r_idx] != 32'd0) && (r_alarm[r_idx] < r_now);
    assign cand      = r_valid[r_idx] && (r_run[r_idx] == RUN_READY);
    assign beats     = cnt_rd > r_best_cnt;

    // Shared saturating increment: ages either the displaced best or the loser.
    assign inc_src = beats ? r_best_cnt : cnt_rd;
    assign inc_res = (inc_src == COUNT_MAX) ? inc_src : inc_src + 16'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_quantum   <= QUANTUM_RESET;
            r_valid     <= NPROC'(1);
            r_cur       <= '0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_best      <= '0;
            r_best_cnt  <= '0;
            for (int i = 0; i < NPROC; i++) begin
                r_run[i]    <= (i == 0) ? RUN_RUNNING : RUN_WAITING;
                r_count[i]  <= '0;
                r_alarm[i]  <= '0;
                r_parent[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_quantum <= i_cfg_data;
            end

            // The output register empties when its item drains and nothing
            // new is loaded behind it.
            if (r_out_valid && i_m_axis_tready && !out_load) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_op   <= t_op'(i_s_axis_tuser);
                        r_proc <= i_s_axis_tdata[3:0];
                        r_par  <= i_s_axis_tdata[7:4];
                        r_at   <= i_s_axis_tdata[39:8];
                        r_now  <= i_s_axis_tdata[71:40];
                        if (t_op'(i_s_axis_tuser) == OP_YIELD ||
                            t_op'(i_s_axis_tuser) == OP_STOP) begin
                            r_idx <= r_cur;
                        end else begin
                            r_idx <= PROC_W'(i_s_axis_tdata[3:0]);
                        end
                        r_state <= S_EXEC;
                    end
                end

                S_EXEC: begin
                    if (out_free) begin
                        unique case (r_op)
                            OP_YIELD: begin
                                if (r_run[r_idx] == RUN_RUNNING) begin
                                    r_run[r_idx]   <= RUN_READY;
                                    r_count[r_idx] <= '0;
                                end
                                r_idx   <= PROC_W'(1);
                                r_state <= S_ALARM;
                            end
                            OP_STOP: begin
                                r_run[r_idx] <= RUN_STOPPED;
                                r_out_valid  <= 1'b1;
                                r_out_kind   <= KIND_CHILD;
                                r_out_target <= 4'(r_parent[r_idx]);
                                r_out_last   <= 1'b0;
                                r_idx        <= PROC_W'(1);
                                r_state      <= S_ALARM;
                            end
                            default: begin
                                case (r_op)
                                    OP_READY: begin
                                        if (proc_ok && r_valid[r_idx]) begin
                                            r_run[r_idx]   <= RUN_READY;
                                            r_count[r_idx] <= '0;
                                        end
                                    end
                                    OP_RESUME: begin
                                        if (proc_ok && r_valid[r_idx] &&
                                            r_run[r_idx] == RUN_STOPPED) begin
                                            r_run[r_idx]   <= RUN_READY;
                                            r_count[r_idx] <= '0;
                                        end
                                    end
                                    OP_CREATE: begin
                                        if (proc_ok && !r_valid[r_idx]) begin
                                            r_valid[r_idx]  <= 1'b1;
                                            r_run[r_idx]    <= RUN_WAITING;
                                            r_count[r_idx]  <= '0;
                                            r_alarm[r_idx]  <= '0;
                                            r_parent[r_idx] <= (32'(r_par) < NPROC) ?
                                                               PROC_W'(r_par) : '0;
                                        end
                                    end
                                    OP_ALARM: begin
                                        if (proc_ok && r_valid[r_idx]) begin
                                            r_alarm[r_idx] <= r_at;
                                        end
                                    end
                                    OP_REMOVE: begin
                                        if (proc_ok) begin
                                            r_valid[r_idx] <= 1'b0;
                                            r_run[r_idx]   <= RUN_WAITING;
                                            r_count[r_idx] <= '0;
                                            r_alarm[r_idx] <= '0;
                                        end
                                    end
                                    default: begin
                                    end
                                endcase
                                r_out_valid  <= 1'b1;
                                r_out_kind   <= KIND_DONE;
                                r_out_target <= 4'd0;
                                r_out_last   <= 1'b1;
                                r_state      <= S_IDLE;
                            end
                        endcase
                    end
                end

                S_ALARM: begin
                    // An expired alarm needs a free output slot before it can move on.
                    if (!alarm_hit || out_free) begin
                        if (alarm_hit) begin
                            r_alarm[r_idx] <= '0;
                            r_out_valid    <= 1'b1;
                            r_out_kind     <= KIND_ALARM;
                            r_out_target   <= 4'(r_idx);
                            r_out_last     <= 1'b0;
                        end
                        if (idx_last) begin
                            r_idx      <= PROC_W'(1);
                            r_best     <= '0;
                            r_best_cnt <= r_count[0];
                            r_state    <= S_SELECT;
                        end else begin
                            r_idx <= r_idx + PROC_W'(1);
                        end
                    end
                end

                S_SELECT: begin
                    if (cand) begin
                        if (beats) begin
                            r_count[r_best] <= inc_res;
                            r_best          <= r_idx;
                            r_best_cnt      <= cnt_rd;
                        end else begin
                            r_count[r_idx] <= inc_res;
                        end
                    end
                    if (idx_last) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_idx <= r_idx + PROC_W'(1);
                    end
                end

                S_FINISH: begin
                    if (out_free) begin
                        r_run[r_best]   <= RUN_RUNNING;
                        r_count[r_best] <= r_quantum;
                        r_cur           <= r_best;
                        r_out_valid     <= 1'b1;
                        r_out_kind      <= KIND_SWITCH;
                        r_out_target    <= 4'(r_best);
                        r_out_last      <= 1'b1;
                        r_state         <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import aps_pkg::*;

    // The run is bounded well above the slowest correct run: every command a
    // full double walk of the table, every result held back by the longest
    // receiver stall, and every command preceded by the longest sender gap.
    localparam int CYCLE_LIMIT = 200000;

    // One result item as the block should present it.
    typedef struct packed {
        t_kind      kind;
        logic [3:0] target;
        logic       last;
    } t_sched_result;

    // Scoreboard: a private copy of the process table that is advanced once
    // per accepted command, and the queue of result items still awaited.
    class sched_scoreboard;
        logic [15:0]       quantum;
        bit                entry_valid [NPROC];
        t_run              run_state   [NPROC];
        logic [15:0]       wait_count  [NPROC];
        logic [31:0]       alarm_at    [NPROC];
        logic [PROC_W-1:0] parent_of   [NPROC];
        logic [PROC_W-1:0] current;

        t_sched_result awaited_results [$];
        t_sched_result staged [$];

        int errors;
        int results_checked;
        int alarms_seen;
        int children_seen;
        int switches_seen;
        int dones_seen;

        function new();
            quantum = QUANTUM_RESET;
            for (int i = 0; i < NPROC; i++) begin
                entry_valid[i] = 1'b0;
                run_state[i]   = RUN_WAITING;
                wait_count[i]  = '0;
                alarm_at[i]    = '0;
                parent_of[i]   = '0;
            end
            entry_valid[0] = 1'b1;
            run_state[0]   = RUN_RUNNING;
            current        = '0;
            errors          = 0;
            results_checked = 0;
            alarms_seen     = 0;
            children_seen   = 0;
            switches_seen   = 0;
            dones_seen      = 0;
        endfunction

        function void stage(t_kind kind, logic [3:0] target);
            t_sched_result r;
            r.kind   = kind;
            r.target = target;
            r.last   = 1'b0;
            staged.push_back(r);
        endfunction

        function void age_entry(int i);
            if (wait_count[i] != COUNT_MAX)
                wait_count[i] = wait_count[i] + 16'd1;
        endfunction

        function void ready_entry(int i);
            run_state[i]  = RUN_READY;
            wait_count[i] = '0;
        endfunction

        // The running entry goes back to ready, expired alarms fire in index
        // order, then the ready entry that has waited longest is chosen. The
        // idle entry is the starting candidate and ties keep the earlier one.
        function void reschedule(logic [31:0] now);
            int chosen;
            chosen = 0;
            if (run_state[current] == RUN_RUNNING)
                ready_entry(current);
            for (int i = 1; i < NPROC; i++) begin
                if (entry_valid[i] && alarm_at[i] != 0 && alarm_at[i] < now) begin
                    alarm_at[i] = '0;
                    stage(KIND_ALARM, i[3:0]);
                end
            end
            for (int i = 1; i < NPROC; i++) begin
                if (entry_valid[i] && run_state[i] == RUN_READY) begin
                    if (wait_count[i] > wait_count[chosen]) begin
                        age_entry(chosen);
                        chosen = i;
                    end else begin
                        age_entry(i);
                    end
                end
            end
            run_state[chosen]  = RUN_RUNNING;
            wait_count[chosen] = quantum;
            current            = chosen[PROC_W-1:0];
            stage(KIND_SWITCH, chosen[3:0]);
        endfunction

        function void predict_command(t_op op, logic [3:0] proc, logic [3:0] parent,
                                      logic [31:0] alarm, logic [31:0] now);
            bit            target_ok;
            t_sched_result r;
            target_ok = (proc != 0) && (int'(proc) < NPROC);
            staged.delete();
            case (op)
                OP_YIELD: begin
                    reschedule(now);
                end
                OP_STOP: begin
                    run_state[current] = RUN_STOPPED;
                    stage(KIND_CHILD, parent_of[current]);
                    reschedule(now);
                end
                OP_READY: begin
                    if (target_ok && entry_valid[proc])
                        ready_entry(proc);
                end
                OP_RESUME: begin
                    if (target_ok && entry_valid[proc] && run_state[proc] == RUN_STOPPED)
                        ready_entry(proc);
                end
                OP_CREATE: begin
                    if (target_ok && !entry_valid[proc]) begin
                        entry_valid[proc] = 1'b1;
                        run_state[proc]   = RUN_WAITING;
                        wait_count[proc]  = '0;
                        alarm_at[proc]    = '0;
                        parent_of[proc]   = (int'(parent) < NPROC) ? parent : '0;
                    end
                end
                OP_ALARM: begin
                    if (target_ok && entry_valid[proc])
                        alarm_at[proc] = alarm;
                end
                OP_REMOVE: begin
                    if (target_ok) begin
                        entry_valid[proc] = 1'b0;
                        run_state[proc]   = RUN_WAITING;
                        wait_count[proc]  = '0;
                        alarm_at[proc]    = '0;
                    end
                end
                default: begin
                end
            endcase
            if (staged.size() == 0)
                stage(KIND_DONE, 4'd0);
            r = staged[staged.size() - 1];
            r.last = 1'b1;
            staged[staged.size() - 1] = r;
            foreach (staged[i])
                awaited_results.push_back(staged[i]);
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH at %0t: %s", $time, msg);
        endtask

        task check_result(t_kind kind, logic [3:0] target, logic last);
            t_sched_result want;
            if (awaited_results.size() == 0) begin
                report($sformatf("result kind %0d target %0d with nothing awaited",
                                 kind, target));
                return;
            end
            want = awaited_results.pop_front();
            results_checked++;
            case (want.kind)
                KIND_ALARM:  alarms_seen++;
                KIND_CHILD:  children_seen++;
                KIND_SWITCH: switches_seen++;
                default:     dones_seen++;
            endcase
            if (kind !== want.kind)
                report($sformatf("kind %0d, wanted %0d", kind, want.kind));
            if (target !== want.target)
                report($sformatf("target %0d, wanted %0d (kind %0d)",
                                 target, want.target, want.kind));
            if (last !== want.last)
                report($sformatf("tlast %0b, wanted %0b (kind %0d)",
                                 last, want.last, want.kind));
        endtask
    endclass

    // Block inputs are all given known values from time zero.
    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic [71:0] i_s_axis_tdata  = '0;
    logic [2:0]  i_s_axis_tuser  = '0;
    logic        i_m_axis_tready = 1'b1;
    logic        i_cfg_valid     = 1'b0;
    logic [15:0] i_cfg_data      = '0;

    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [7:0]  o_m_axis_tdata;
    logic [1:0]  o_m_axis_tuser;
    logic        o_m_axis_tlast;
    logic        o_cfg_ready;

    sched_scoreboard sb;

    int          cycle_count    = 0;
    int          commands_sent  = 0;
    int          quantum_writes = 0;
    int          burst_left     = 0;
    logic [31:0] tick           = '0;

    // Receiver stall pattern: a mode is kept for a random stretch of cycles.
    int   rx_mode     = 0;
    int   rx_mode_left = 0;
    int   rx_run_left = 0;
    logic rx_level    = 1'b1;

    aging_process_scheduler dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    // 12 ns clock, starting low.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Watchdog: a run that has not finished by now is a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    // The receiver switches between being always ready, dropping ready at
    // random, and holding ready low for longer runs. Inputs change only at
    // the falling edge, so the block sees them settled at the rising edge.
    always @(negedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(0, 2);
            rx_mode_left = $urandom_range(20, 80);
        end else begin
            rx_mode_left--;
        end
        case (rx_mode)
            0: i_m_axis_tready = 1'b1;
            1: i_m_axis_tready = ($urandom_range(0, 9) < 7);
            default: begin
                if (rx_run_left == 0) begin
                    rx_level    = !rx_level;
                    rx_run_left = rx_level ? $urandom_range(1, 4) : $urandom_range(1, 8);
                end else begin
                    rx_run_left--;
                end
                i_m_axis_tready = rx_level;
            end
        endcase
    end

    // Result items are sampled at the rising edge, before the block's own
    // updates of that edge take effect.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_result(t_kind'(o_m_axis_tuser), o_m_axis_tdata[3:0], o_m_axis_tlast);
    end

    // Presents one command and waits for it to be taken. It is entered and
    // left at a falling edge, with valid still high, so that a following
    // command can go out back to back.
    task send_cmd(input t_op op, input logic [3:0] proc, input logic [3:0] parent,
                  input logic [31:0] alarm, input logic [31:0] now);
        i_s_axis_tuser  = op;
        i_s_axis_tdata  = {now, alarm, parent, proc};
        i_s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.predict_command(op, proc, parent, alarm, now);
        commands_sent++;
        @(negedge i_clk);
    endtask

    // The sender works in bursts; between bursts valid is dropped for a gap
    // that is usually short and now and then long enough to outlast a walk.
    task issue(input t_op op, input logic [3:0] proc, input logic [3:0] parent,
               input logic [31:0] alarm, input logic [31:0] now);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
            i_s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        send_cmd(op, proc, parent, alarm, now);
    endtask

    // Holds the sender back until every awaited result item has come.
    task drain();
        i_s_axis_tvalid = 1'b0;
        burst_left      = 0;
        while (sb.awaited_results.size() != 0)
            @(negedge i_clk);
    endtask

    // The quantum is only written with the block idle, after a drain.
    task write_quantum(input logic [15:0] value);
        i_cfg_data  = value;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.quantum = value;
        quantum_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Picks an entry other than idle: want 0 asks for a free one, 1 for a
    // valid one and 2 for a stopped one. With no such entry any is taken.
    function logic [3:0] pick_entry(input int want);
        int candidates [$];
        int i;
        for (i = 1; i < NPROC; i++) begin
            if ((want == 0 && !sb.entry_valid[i]) ||
                (want == 1 && sb.entry_valid[i]) ||
                (want == 2 && sb.entry_valid[i] && sb.run_state[i] == RUN_STOPPED))
                candidates.push_back(i);
        end
        if (candidates.size() == 0)
            return 4'($urandom_range(1, NPROC - 1));
        i = candidates[$urandom_range(0, candidates.size() - 1)];
        return i[3:0];
    endfunction

    // Random commands are mostly aimed at entries for which they mean
    // something, so that the table fills, alarms fire and the choice of the
    // next entry has several candidates. The rest hit any entry, idle too.
    task random_item();
        int          roll;
        t_op         op;
        logic [3:0]  proc;
        logic [3:0]  parent;
        logic [31:0] alarm;
        logic [31:0] now;
        roll = $urandom_range(0, 99);
        if (roll < 22)      op = OP_YIELD;
        else if (roll < 30) op = OP_STOP;
        else if (roll < 48) op = OP_READY;
        else if (roll < 55) op = OP_RESUME;
        else if (roll < 70) op = OP_CREATE;
        else if (roll < 84) op = OP_ALARM;
        else if (roll < 96) op = OP_REMOVE;
        else                op = OP_UNUSED;

        case (op)
            OP_CREATE: proc = pick_entry(0);
            OP_RESUME: proc = pick_entry(2);
            OP_REMOVE: proc = ($urandom_range(0, 9) < 3) ? sb.current : pick_entry(1);
            default:   proc = pick_entry(1);
        endcase
        if ($urandom_range(0, 99) < 15)
            proc = 4'($urandom_range(0, 15));
        parent = 4'($urandom_range(0, 15));

        // Time mostly creeps forward, with an occasional jump anywhere.
        if ($urandom_range(0, 99) < 8)
            tick = $urandom;
        else
            tick = tick + $urandom_range(0, 25);
        now = tick;

        roll = $urandom_range(0, 99);
        if (roll < 60)      alarm = tick + $urandom_range(0, 40);
        else if (roll < 75) alarm = '0;
        else                alarm = $urandom;

        issue(op, proc, parent, alarm, now);
    endtask

    task run_random(input int count);
        repeat (count) random_item();
    endtask

    initial begin
        logic [3:0]  stopped_proc;
        logic [15:0] mid_quantum;

        sb = new();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, run with the quantum left at its reset value.
        // A yield and a stop straight after reset, with only idle present.
        issue(OP_YIELD,  4'd0,  4'd0,  32'd0,          32'd0);
        issue(OP_STOP,   4'd0,  4'd0,  32'd0,          32'd0);
        // The unused code with every field at its top value.
        issue(OP_UNUSED, 4'hF,  4'hF,  32'hFFFF_FFFF,  32'hFFFF_FFFF);
        // Idle as the target, and commands on entries that do not exist.
        issue(OP_CREATE, 4'd0,  4'd3,  32'd0,          32'd0);
        issue(OP_READY,  4'd5,  4'd0,  32'd0,          32'd0);
        issue(OP_ALARM,  4'd9,  4'd0,  32'd100,        32'd0);
        // Create, including the top entry and a repeated create.
        issue(OP_CREATE, 4'd1,  4'd0,  32'd0,          32'd0);
        issue(OP_CREATE, 4'd2,  4'd1,  32'd0,          32'd0);
        issue(OP_CREATE, 4'd15, 4'd15, 32'd0,          32'd0);
        issue(OP_CREATE, 4'd1,  4'd7,  32'd0,          32'd0);
        // Resume of an entry that is not stopped does nothing.
        issue(OP_RESUME, 4'd1,  4'd0,  32'd0,          32'd0);
        issue(OP_READY,  4'd1,  4'd0,  32'd0,          32'd0);
        issue(OP_READY,  4'd2,  4'd0,  32'd0,          32'd0);
        issue(OP_READY,  4'd15, 4'd0,  32'd0,          32'd0);
        issue(OP_ALARM,  4'd1,  4'd0,  32'd100,        32'd0);
        issue(OP_ALARM,  4'd2,  4'd0,  32'hFFFF_FFFF,  32'd0);
        issue(OP_ALARM,  4'd15, 4'd0,  32'd200,        32'd0);
        // An alarm equal to the current tick has not expired yet; one tick
        // later it has.
        issue(OP_YIELD,  4'd0,  4'd0,  32'd0,          32'd100);
        issue(OP_YIELD,  4'd0,  4'd0,  32'd0,          32'd101);
        // Stop the current entry, then bring it back.
        stopped_proc = sb.current;
        issue(OP_STOP,   4'd0,  4'd0,  32'd0,          32'd101);
        issue(OP_RESUME, stopped_proc, 4'd0, 32'd0,    32'd101);
        // Removing the running entry leaves it out of the next choice.
        issue(OP_REMOVE, sb.current, 4'd0, 32'd0,      32'd150);
        issue(OP_YIELD,  4'd0,  4'd0,  32'd0,          32'd150);
        // An alarm set to zero never fires, even at the top tick.
        issue(OP_ALARM,  4'd2,  4'd0,  32'd0,          32'd150);
        issue(OP_YIELD,  4'd0,  4'd0,  32'd0,          32'hFFFF_FFFF);
        issue(OP_REMOVE, 4'd0,  4'd0,  32'd0,          32'd0);
        tick = 32'd200;

        // Random part in three settings of the quantum: the smallest, the
        // largest and one in between. Each write waits for the block to go
        // idle with nothing left awaited.
        drain();
        write_quantum(16'd1);
        run_random(25);

        drain();
        write_quantum(16'hFFFF);
        run_random(25);

        drain();
        mid_quantum = 16'($urandom_range(2, 16'hFFFE));
        write_quantum(mid_quantum);
        run_random(25);

        // Wait for the last results, then a little longer in case anything
        // extra comes out of the block.
        drain();
        repeat (2 * NPROC + 8) @(negedge i_clk);

        $display("summary: %0d commands, %0d quantum settings, %0d results checked",
                 commands_sent, quantum_writes, sb.results_checked);
        $display("summary: %0d alarms, %0d child signals, %0d switches, %0d done",
                 sb.alarms_seen, sb.children_seen, sb.switches_seen, sb.dones_seen);
        if (sb.errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

### sim.f
src/aps_pkg.sv
src/aging_process_scheduler.sv
bench/tb.sv
